/* hdl/oc_density_update_macros.svh */
// ----------------------------------------------------------------------------
// oc_density_update_macros.svh
// Assertion shorthands for the density update block. All checks are clocked
// on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OC_DENSITY_UPDATE_MACROS_SVH
`define OC_DENSITY_UPDATE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ODU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ODU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/odu_pkg.sv */
// ----------------------------------------------------------------------------
// odu_pkg
// Shared types, widths and constants of the density update block.
// ----------------------------------------------------------------------------
`default_nettype none

package odu_pkg;

  // sizing
  localparam int MAX_ELEMENTS  = 4096;
  localparam int FRACTION_BITS = 16;
  localparam int ADDR_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W         = ADDR_W + 1;

  // field widths
  localparam int DENS_W = 17;
  localparam int SENS_W = 32;
  localparam int IDX_W  = 12;
  localparam int VOL_W  = 29;
  localparam int CFG_W  = 29;
  localparam int CFG_IDX_W = 2;

  // arithmetic widths
  localparam int LAM_W  = 17 + FRACTION_BITS;   // 100000 < 2^17
  localparam int XX_W   = 2 * DENS_W;           // x*x
  localparam int PP_W   = DENS_W + SENS_W;      // half of x*x times s
  localparam int NUM_W  = XX_W + SENS_W;        // x*x*s
  localparam int Q_W    = 37;                   // quotient, capped at 2^36
  localparam int RES_W  = 19;                   // sqrt of the capped quotient
  localparam int DCNT_W = $clog2(Q_W + 1);
  localparam int SUM_W  = CNT_W + DENS_W;
  localparam int CMPV_W = (SUM_W > VOL_W) ? SUM_W : VOL_W;
  localparam int MEM_W  = DENS_W + SENS_W + 1;

  // constants
  localparam longint ONE_FULL = longint'(1) << FRACTION_BITS;
  localparam logic [DENS_W-1:0] ONE_FX =
    (ONE_FULL > longint'(131071)) ? {DENS_W{1'b1}} : DENS_W'(ONE_FULL);
  localparam longint EPS_RAW = ONE_FULL / 10000;
  localparam logic [LAM_W-1:0] LAM_EPS = LAM_W'((EPS_RAW < 1) ? 1 : EPS_RAW);
  localparam logic [LAM_W-1:0] LAM_TOP = LAM_W'(100000) << FRACTION_BITS;
  localparam logic [Q_W-1:0]   Q_CAP   = Q_W'(1) << (Q_W - 1);

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN    = 2'd2;
  localparam logic [VOL_W-1:0]  VOL_RESET  = 29'd134217728;
  localparam logic [DENS_W-1:0] MOVE_RESET = 17'd13107;
  localparam logic [DENS_W-1:0] MIN_RESET  = 17'd655;

  // item actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic              action;
    logic [IDX_W-1:0]  element_index;
    logic [DENS_W-1:0] density_in;
    logic [SENS_W-1:0] sensitivity_mag;
    logic              is_fixed;
    logic              last_element;
  } in_item_t;

  typedef struct packed {
    logic [DENS_W-1:0] new_density;
    logic [IDX_W-1:0]  out_index;
    logic              update_ready;
  } out_item_t;

  typedef struct packed {
    logic [DENS_W-1:0] dens;
    logic [SENS_W-1:0] sens;
    logic              fixed;
  } elem_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_PASS, S_FETCH, S_MUL1, S_MUL2, S_MUL3, S_MUL4,
    S_DIVCHK, S_DIV, S_SQRT0, S_SQRT, S_CLAMP, S_PEND
  } state_t;

  typedef struct packed {
    logic load;
    logic lam_init;
    logic rd_issue;
    logic out_load;
    logic pass_start;
    logic set_done;
    logic fetch;
    logic mul1;
    logic mul2;
    logic mul3;
    logic mul4;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic clamp_wr;
    logic pass_end;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic cnt_zero;
    logic last_k;
    logic fixed;
    logic div_sat;
    logic div_last;
    logic sqrt_last;
    logic out_free;
    logic done;
  } sts_t;

endpackage

`default_nettype wire

/* hdl/odu_ctrl.sv */
// ----------------------------------------------------------------------------
// odu_ctrl
// Sequencer: takes items, runs the bisection passes and the per-element
// multiply / divide / root / clamp steps on the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module odu_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_action,
  input  wire logic          in_last,
  output logic               in_stall,
  input  wire odu_pkg::sts_t sts,
  output odu_pkg::cmd_t      cmd
);

  odu_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= odu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      odu_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_action == odu_pkg::ACT_READ) begin
            state_nxt = odu_pkg::S_READ;
          end else if (in_last) begin
            state_nxt = odu_pkg::S_PASS;
          end
        end
      end
      odu_pkg::S_READ: begin
        if (sts.out_free) state_nxt = odu_pkg::S_IDLE;
      end
      odu_pkg::S_PASS: begin
        if (!sts.more) state_nxt = odu_pkg::S_IDLE;
        else if (sts.cnt_zero) state_nxt = odu_pkg::S_PEND;
        else state_nxt = odu_pkg::S_FETCH;
      end
      odu_pkg::S_FETCH:  state_nxt = odu_pkg::S_MUL1;
      odu_pkg::S_MUL1:   state_nxt = sts.fixed ? odu_pkg::S_CLAMP : odu_pkg::S_MUL2;
      odu_pkg::S_MUL2:   state_nxt = odu_pkg::S_MUL3;
      odu_pkg::S_MUL3:   state_nxt = odu_pkg::S_MUL4;
      odu_pkg::S_MUL4:   state_nxt = odu_pkg::S_DIVCHK;
      odu_pkg::S_DIVCHK: state_nxt = sts.div_sat ? odu_pkg::S_SQRT0 : odu_pkg::S_DIV;
      odu_pkg::S_DIV: begin
        if (sts.div_last) state_nxt = odu_pkg::S_SQRT0;
      end
      odu_pkg::S_SQRT0:  state_nxt = odu_pkg::S_SQRT;
      odu_pkg::S_SQRT: begin
        if (sts.sqrt_last) state_nxt = odu_pkg::S_CLAMP;
      end
      odu_pkg::S_CLAMP:  state_nxt = sts.last_k ? odu_pkg::S_PEND : odu_pkg::S_FETCH;
      odu_pkg::S_PEND:   state_nxt = odu_pkg::S_PASS;
      default:           state_nxt = odu_pkg::S_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != odu_pkg::S_IDLE);
    case (state_r)
      odu_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_action == odu_pkg::ACT_READ) begin
            cmd.rd_issue = 1'b1;
          end else begin
            cmd.load     = 1'b1;
            cmd.lam_init = in_last;
          end
        end
      end
      odu_pkg::S_READ:   cmd.out_load = sts.out_free;
      odu_pkg::S_PASS: begin
        cmd.pass_start = sts.more;
        cmd.set_done   = !sts.more;
      end
      odu_pkg::S_FETCH:  cmd.fetch     = 1'b1;
      odu_pkg::S_MUL1:   cmd.mul1      = 1'b1;
      odu_pkg::S_MUL2:   cmd.mul2      = 1'b1;
      odu_pkg::S_MUL3:   cmd.mul3      = 1'b1;
      odu_pkg::S_MUL4:   cmd.mul4      = 1'b1;
      odu_pkg::S_DIVCHK: cmd.div_init  = 1'b1;
      odu_pkg::S_DIV:    cmd.div_step  = 1'b1;
      odu_pkg::S_SQRT0:  cmd.sqrt_init = 1'b1;
      odu_pkg::S_SQRT:   cmd.sqrt_step = 1'b1;
      odu_pkg::S_CLAMP:  cmd.clamp_wr  = 1'b1;
      odu_pkg::S_PEND:   cmd.pass_end  = 1'b1;
      default:           cmd           = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/odu_dp.sv */
// ----------------------------------------------------------------------------
// odu_dp
// Datapath: element and result memories, configuration registers, lambda
// bisection registers, split multiplier, bit-serial divider, bit-serial
// square root, clamps, volume sum and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module odu_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire odu_pkg::in_item_t              in_data,
  output odu_pkg::out_item_t                  out_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  input  wire logic                           cfg_we,
  input  wire logic [odu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [odu_pkg::CFG_W-1:0]      cfg_data,
  input  wire odu_pkg::cmd_t                  cmd,
  output odu_pkg::sts_t                       sts
);

  localparam int AW = odu_pkg::ADDR_W;
  localparam int CW = odu_pkg::CNT_W;
  localparam int DW = odu_pkg::DENS_W;
  localparam int LW = odu_pkg::LAM_W;
  localparam int QW = odu_pkg::Q_W;
  localparam int RW = odu_pkg::RES_W;
  localparam int NW = odu_pkg::NUM_W;
  localparam int SW = odu_pkg::SUM_W;
  localparam int CMPW = odu_pkg::CMPV_W;

  // memories
  odu_pkg::elem_t    elem_mem [odu_pkg::MAX_ELEMENTS];
  logic [DW-1:0]     nd_mem   [odu_pkg::MAX_ELEMENTS];
  odu_pkg::elem_t    elem_rd_r;
  logic [DW-1:0]     nd_rd_r;

  // control and config registers
  logic [CW-1:0]                count_r;
  logic                         done_r;
  logic [odu_pkg::VOL_W-1:0]    vol_r;
  logic [DW-1:0]                move_r;
  logic [DW-1:0]                min_r;
  logic [LW-1:0]                lam_lo_r, lam_hi_r, mid_r;
  logic [AW-1:0]                k_r;
  logic [SW-1:0]                sum_r;

  // read path
  logic [odu_pkg::IDX_W-1:0]    rd_idx_r;
  logic                         rd_ok_r;
  logic                         out_valid_r;
  odu_pkg::out_item_t           out_data_r;

  // arithmetic registers
  logic [odu_pkg::XX_W-1:0]     xx_r;
  logic [odu_pkg::PP_W-1:0]     pl_r, ph_r;
  logic [NW-1:0]                prod_r;
  logic [LW-1:0]                rem_r;
  logic [QW-1:0]                sh_r;
  logic [odu_pkg::DCNT_W-1:0]   dcnt_r;
  logic [QW-1:0]                v_r, res_r, bit_r;

  // combinational helpers
  logic [AW-1:0]     wr_addr;
  logic              wr_ok;
  logic              rd_ok;
  logic [LW-1:0]     lam_span;
  logic [NW-QW-1:0]  num_hi;
  logic              div_sat;
  logic [LW:0]       rem2;
  logic              rem_ge;
  logic [QW:0]       sq_t;
  logic              sq_ge;
  logic [RW-1:0]     x19, mv19, xm, c0, c1, c2, c3, c4;
  logic [DW-1:0]     c_fin;

  // load addressing: a load after a finished update restarts at slot zero
  assign wr_addr = done_r ? '0 : count_r[AW-1:0];
  assign wr_ok   = done_r || (count_r < CW'(odu_pkg::MAX_ELEMENTS));
  assign rd_ok   = done_r && (32'(in_data.element_index) < 32'(count_r));
  assign lam_span = lam_hi_r - lam_lo_r;

  // divider: saturate when the top part already reaches the divisor
  assign num_hi  = prod_r[NW-1:QW];
  assign div_sat = NW'(num_hi) >= NW'(mid_r);
  assign rem2    = {rem_r, sh_r[QW-1]};
  assign rem_ge  = rem2 >= (LW+1)'(mid_r);

  // square root step
  assign sq_t  = (QW+1)'(res_r) + (QW+1)'(bit_r);
  assign sq_ge = (QW+1)'(v_r) >= sq_t;

  // clamps: move limit, one, lower move limit, minimum density
  assign x19  = RW'(elem_rd_r.dens);
  assign mv19 = RW'(move_r);
  assign xm   = x19 + mv19;
  assign c0   = res_r[RW-1:0];
  assign c1   = (c0 > xm) ? xm : c0;
  assign c2   = (c1 > RW'(odu_pkg::ONE_FX)) ? RW'(odu_pkg::ONE_FX) : c1;
  assign c3   = ((x19 >= mv19) && ((x19 - mv19) > c2)) ? (x19 - mv19) : c2;
  assign c4   = (c3 < RW'(min_r)) ? RW'(min_r) : c3;
  assign c_fin = elem_rd_r.fixed ? odu_pkg::ONE_FX : c4[DW-1:0];

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) begin
      elem_mem[wr_addr] <= '{dens: in_data.density_in, sens: in_data.sensitivity_mag,
                             fixed: in_data.is_fixed};
    end
    if (cmd.fetch) elem_rd_r <= elem_mem[k_r];
    if (cmd.clamp_wr) nd_mem[k_r] <= c_fin;
    if (cmd.rd_issue) nd_rd_r <= nd_mem[AW'(in_data.element_index)];
  end

  // control state, configuration, lambda bounds, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      done_r      <= 1'b0;
      vol_r       <= odu_pkg::VOL_RESET;
      move_r      <= odu_pkg::MOVE_RESET;
      min_r       <= odu_pkg::MIN_RESET;
      lam_lo_r    <= '0;
      lam_hi_r    <= odu_pkg::LAM_TOP;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          odu_pkg::REG_VOLUME: vol_r  <= cfg_data[odu_pkg::VOL_W-1:0];
          odu_pkg::REG_MOVE:   move_r <= cfg_data[DW-1:0];
          odu_pkg::REG_MIN:    min_r  <= cfg_data[DW-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        done_r <= 1'b0;
        if (done_r) count_r <= CW'(1);
        else if (wr_ok) count_r <= count_r + CW'(1);
      end
      if (cmd.lam_init) begin
        lam_lo_r <= '0;
        lam_hi_r <= odu_pkg::LAM_TOP;
      end
      if (cmd.set_done) done_r <= 1'b1;
      if (cmd.pass_end) begin
        if (CMPW'(sum_r) > CMPW'(vol_r)) lam_lo_r <= mid_r;
        else lam_hi_r <= mid_r;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // pass bookkeeping and read capture
  always_ff @(posedge clk) begin
    if (cmd.pass_start) begin
      mid_r <= lam_lo_r + (lam_span >> 1);
      k_r   <= '0;
      sum_r <= '0;
    end
    if (cmd.clamp_wr) begin
      sum_r <= sum_r + SW'(c_fin);
      k_r   <= k_r + AW'(1);
    end
    if (cmd.rd_issue) begin
      rd_idx_r <= in_data.element_index;
      rd_ok_r  <= rd_ok;
    end
    if (cmd.out_load) begin
      out_data_r.new_density  <= rd_ok_r ? nd_rd_r : '0;
      out_data_r.out_index    <= rd_idx_r;
      out_data_r.update_ready <= done_r;
    end
  end

  // multiply x*x*s in three products, then divide and take the root
  always_ff @(posedge clk) begin
    if (cmd.mul1) xx_r <= odu_pkg::XX_W'(elem_rd_r.dens) * odu_pkg::XX_W'(elem_rd_r.dens);
    if (cmd.mul2) pl_r <= odu_pkg::PP_W'(xx_r[DW-1:0]) * odu_pkg::PP_W'(elem_rd_r.sens);
    if (cmd.mul3) begin
      ph_r <= odu_pkg::PP_W'(xx_r[odu_pkg::XX_W-1:DW]) * odu_pkg::PP_W'(elem_rd_r.sens);
    end
    if (cmd.mul4) prod_r <= NW'(pl_r) + (NW'(ph_r) << DW);
    if (cmd.div_init) begin
      if (div_sat) begin
        sh_r   <= odu_pkg::Q_CAP;
        dcnt_r <= '0;
      end else begin
        rem_r  <= LW'(num_hi);
        sh_r   <= prod_r[QW-1:0];
        dcnt_r <= odu_pkg::DCNT_W'(QW);
      end
    end
    if (cmd.div_step) begin
      rem_r  <= rem_ge ? LW'(rem2 - (LW+1)'(mid_r)) : rem2[LW-1:0];
      sh_r   <= {sh_r[QW-2:0], rem_ge};
      dcnt_r <= dcnt_r - odu_pkg::DCNT_W'(1);
    end
    if (cmd.sqrt_init) begin
      v_r   <= (sh_r > odu_pkg::Q_CAP) ? odu_pkg::Q_CAP : sh_r;
      res_r <= '0;
      bit_r <= QW'(1) << (QW - 1);
    end
    if (cmd.sqrt_step) begin
      if (sq_ge) begin
        v_r   <= v_r - QW'(sq_t);
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // status to the sequencer
  always_comb begin
    sts           = '0;
    sts.more      = lam_span > odu_pkg::LAM_EPS;
    sts.cnt_zero  = (count_r == '0);
    sts.last_k    = ((CW'(k_r) + CW'(1)) == count_r);
    sts.fixed     = elem_rd_r.fixed;
    sts.div_sat   = div_sat;
    sts.div_last  = (dcnt_r == odu_pkg::DCNT_W'(1));
    sts.sqrt_last = bit_r[0];
    sts.out_free  = !out_valid_r || !out_stall;
    sts.done      = done_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* hdl/oc_density_update.sv */
// Read: data fetched at its transfer, moved to the output register in the READ state,
// which waits while a result is stalled. Update: the last load starts about 31 bisection
// passes, each fetching, multiplying, dividing and rooting (bit-serially) and clamping
// every element; a saturated quotient skips the divide, a fixed element goes from the
// first multiply to the clamp. Loads: one item per cycle when idle; busy during update.
// Reset: synchronous, active low; clears count, done, out valid; sets lambda bounds, config.
// ----------------------------------------------------------------------------
// oc_density_update
// Optimality-criteria density update: stores elements, bisects the Lagrange
// multiplier against the volume target and returns updated densities.
// ----------------------------------------------------------------------------
`default_nettype none

`include "oc_density_update_macros.svh"

module oc_density_update (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire odu_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output odu_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [odu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [odu_pkg::CFG_W-1:0]      cfg_data
);

  odu_pkg::cmd_t cmd;
  odu_pkg::sts_t sts;
  logic          last_load_xfer;

  // sequencer
  odu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_last   (in_data.last_element),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  odu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // transfer of a load that starts an update
  assign last_load_xfer = in_valid && !in_stall && in_data.last_element &&
                          (in_data.action == odu_pkg::ACT_LOAD);

  // checks
  `ODU_ASSERT_NEXT(a_last_load_clears_done, last_load_xfer, !sts.done, "done survived a load")
  `ODU_ASSERT_NOW(a_done_after_busy, $rose(sts.done), $past(in_stall), "done set while idle")
  `ODU_ASSERT_NOW(a_result_from_read, $rose(out_valid), $past(in_stall), "result without a read")

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Density update block testbench
// Loads element batches, lets the block bisect the multiplier and reads the
// updated densities back. A scoreboard object predicts every read result from
// its own copy of the element stores and registers, and compares field by field.
// ----------------------------------------------------------------------------

class density_scoreboard;
  logic [odu_pkg::DENS_W-1:0] dens_mem [odu_pkg::MAX_ELEMENTS];
  logic [odu_pkg::SENS_W-1:0] sens_mem [odu_pkg::MAX_ELEMENTS];
  logic                       pin_mem  [odu_pkg::MAX_ELEMENTS];
  logic [odu_pkg::DENS_W-1:0] upd_mem  [odu_pkg::MAX_ELEMENTS];
  int                         n_loaded;
  bit                         solved;
  longint unsigned            vol_target, move_lim, dens_floor;
  odu_pkg::out_item_t         expected_reads[$];
  int                         n_errors;

  function new();
    n_loaded   = 0;
    solved     = 0;
    vol_target = 64'(odu_pkg::VOL_RESET);
    move_lim   = 64'(odu_pkg::MOVE_RESET);
    dens_floor = 64'(odu_pkg::MIN_RESET);
    n_errors   = 0;
  endfunction

  function void set_reg(logic [odu_pkg::CFG_IDX_W-1:0] idx, logic [odu_pkg::CFG_W-1:0] val);
    case (idx)
      odu_pkg::REG_VOLUME: vol_target = 64'(val[odu_pkg::VOL_W-1:0]);
      odu_pkg::REG_MOVE:   move_lim   = 64'(val[odu_pkg::DENS_W-1:0]);
      odu_pkg::REG_MIN:    dens_floor = 64'(val[odu_pkg::DENS_W-1:0]);
      default: ;
    endcase
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // candidate density of one element for a given multiplier
  function longint unsigned candidate(int k, longint unsigned lam);
    logic [127:0]    num, quo;
    longint unsigned x, c, one;
    one = 64'd1 << odu_pkg::FRACTION_BITS;
    if (one > 131071) one = 131071;
    if (pin_mem[k]) return one;
    x   = 64'(dens_mem[k]);
    num = 128'(x * x) * 128'(sens_mem[k]);
    quo = num / 128'(lam);
    if (quo > (128'd1 << 36)) quo = 128'd1 << 36;
    c = int_sqrt(quo[63:0]);
    if (c > x + move_lim) c = x + move_lim;
    if (c > one) c = one;
    if (x >= move_lim && x - move_lim > c) c = x - move_lim;
    if (c < dens_floor) c = dens_floor;
    return c;
  endfunction

  // bisection on the multiplier against the volume target
  function void solve_lambda();
    longint unsigned lo, hi, mid, total, c, eps;
    eps = (64'd1 << odu_pkg::FRACTION_BITS) / 10000;
    if (eps < 1) eps = 1;
    lo = 0;
    hi = 64'd100000 << odu_pkg::FRACTION_BITS;
    while (hi - lo > eps) begin
      mid = lo + ((hi - lo) >> 1);
      total = 0;
      for (int k = 0; k < n_loaded; k++) begin
        c = candidate(k, mid);
        upd_mem[k] = c[odu_pkg::DENS_W-1:0];
        total += c;
      end
      if (total > vol_target) lo = mid;
      else hi = mid;
    end
    solved = 1;
  endfunction

  function void note_input(odu_pkg::in_item_t it);
    odu_pkg::out_item_t r;
    if (it.action == odu_pkg::ACT_LOAD) begin
      if (solved) begin
        solved = 0;
        n_loaded = 0;
      end
      if (n_loaded < odu_pkg::MAX_ELEMENTS) begin
        dens_mem[n_loaded] = it.density_in;
        sens_mem[n_loaded] = it.sensitivity_mag;
        pin_mem[n_loaded]  = it.is_fixed;
        n_loaded++;
      end
      if (it.last_element) solve_lambda();
    end else begin
      r.new_density  = (solved && it.element_index < n_loaded) ?
                       upd_mem[it.element_index] : '0;
      r.out_index    = it.element_index;
      r.update_ready = solved;
      expected_reads = {expected_reads, r};
    end
  endfunction

  function void check_result(odu_pkg::out_item_t got);
    odu_pkg::out_item_t exp_r;
    if (expected_reads.size() == 0) begin
      n_errors++;
      if (n_errors <= 10) $display("unexpected result: %p", got);
      return;
    end
    exp_r = expected_reads.pop_front();
    if (got.new_density !== exp_r.new_density || got.out_index !== exp_r.out_index ||
        got.update_ready !== exp_r.update_ready) begin
      n_errors++;
      if (n_errors <= 10)
        $display("mismatch: expected dens %0d idx %0d rdy %0d, got dens %0d idx %0d rdy %0d",
                 exp_r.new_density, exp_r.out_index, exp_r.update_ready,
                 got.new_density, got.out_index, got.update_ready);
    end
  endfunction
endclass

module testbench;
  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  odu_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_stall;
  odu_pkg::out_item_t            out_data;
  logic                          cfg_we;
  logic [odu_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [odu_pkg::CFG_W-1:0]     cfg_data;

  density_scoreboard sb;
  int n_items;
  int stall_run;
  bit stall_quiet;

  oc_density_update u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // random gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic odu_pkg::in_item_t load_item(logic [odu_pkg::DENS_W-1:0] x,
                                                  logic [odu_pkg::SENS_W-1:0] s,
                                                  logic pin, logic last);
    odu_pkg::in_item_t it;
    it.action          = odu_pkg::ACT_LOAD;
    it.element_index   = odu_pkg::IDX_W'($urandom_range(0, 4095));
    it.density_in      = x;
    it.sensitivity_mag = s;
    it.is_fixed        = pin;
    it.last_element    = last;
    return it;
  endfunction

  function automatic odu_pkg::in_item_t read_item(logic [odu_pkg::IDX_W-1:0] idx);
    odu_pkg::in_item_t it;
    it.action          = odu_pkg::ACT_READ;
    it.element_index   = idx;
    it.density_in      = odu_pkg::DENS_W'($urandom_range(0, 131071));
    it.sensitivity_mag = $urandom;
    it.is_fixed        = 1'($urandom_range(0, 1));
    it.last_element    = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic odu_pkg::in_item_t rand_load(logic last);
    logic [odu_pkg::DENS_W-1:0] x;
    logic [odu_pkg::SENS_W-1:0] s;
    case ($urandom_range(0, 3))
      0: x = odu_pkg::DENS_W'($urandom_range(0, 65536));
      1: x = odu_pkg::DENS_W'($urandom_range(60000, 65536));
      default: x = odu_pkg::DENS_W'($urandom_range(0, 40000));
    endcase
    s = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 1 << 22);
    return load_item(x, s, ($urandom_range(0, 7) == 0), last);
  endfunction

  // one transfer on the input channel; returns at the accepting edge, or after the gap
  task automatic send(odu_pkg::in_item_t it, int gap);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    n_items++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // a read stalls while an update runs, so its result marks an idle block
  task automatic drain();
    send(read_item(12'd0), 0);
    in_valid <= 1'b0;
    while (sb.expected_reads.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [odu_pkg::CFG_IDX_W-1:0] idx, logic [odu_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_regs(logic [odu_pkg::CFG_W-1:0] vol, logic [odu_pkg::CFG_W-1:0] mv,
                          logic [odu_pkg::CFG_W-1:0] mn);
    drain();
    write_reg(odu_pkg::REG_VOLUME, vol);
    write_reg(odu_pkg::REG_MOVE, mv);
    write_reg(odu_pkg::REG_MIN, mn);
  endtask

  // one batch of loads closed by a last flag, now and then a read between loads, then reads
  task automatic run_batch(int n_elem, int n_reads);
    for (int k = 0; k < n_elem; k++) begin
      if ($urandom_range(0, 15) == 0)
        send(read_item(odu_pkg::IDX_W'($urandom_range(0, 7))), pick_gap());
      send(rand_load(k == n_elem - 1), pick_gap());
    end
    for (int k = 0; k < n_reads; k++)
      send(read_item(odu_pkg::IDX_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                         : $urandom_range(0, n_elem))),
           pick_gap());
  endtask

  // result side: random stall with quiet stretches, check every transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_run   <= 0;
      stall_quiet <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (stall_run > 0) begin
        stall_run <= stall_run - 1;
      end else if ($urandom_range(0, 199) == 0) begin
        stall_quiet <= ~stall_quiet;
      end else if (!stall_quiet) begin
        case ($urandom_range(0, 19))
          0:       stall_run <= $urandom_range(10, 40);
          1, 2, 3: stall_run <= $urandom_range(1, 3);
          default: stall_run <= 0;
        endcase
        out_stall <= ($urandom_range(0, 2) == 0);
      end else begin
        out_stall <= 1'b0;
      end
      if (stall_run > 0) out_stall <= 1'b1;
    end
  end

  // stimulus
  initial begin
    sb        = new();
    n_items   = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = odu_pkg::REG_VOLUME;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // read before any update, then field extremes and zero sensitivity
    send(read_item(12'd0), 0);
    send(read_item(12'hFFF), 1);
    send(load_item(17'd0, 32'hFFFF_FFFF, 1'b0, 1'b0), 0);
    send(load_item(17'd65536, 32'hFFFF_FFFF, 1'b0, 1'b0), 0);
    send(load_item(17'd65536, 32'd0, 1'b0, 1'b0), 2);
    send(read_item(12'd1), 0);
    send(load_item(17'd32768, 32'd1, 1'b1, 1'b0), 0);
    send(load_item(17'd1, 32'h8000_0000, 1'b0, 1'b1), 0);
    for (int k = 0; k < 6; k++) send(read_item(odu_pkg::IDX_W'(k)), 0);
    send(read_item(12'hFFF), 0);
    // load after an update opens a new batch
    send(load_item(17'd20000, 32'h0001_0000, 1'b0, 1'b1), 0);
    send(read_item(12'd0), 0);
    send(read_item(12'd1), 0);

    // register extremes
    set_regs(29'd0, 29'd0, 29'd0);
    run_batch(3, 4);
    set_regs(29'd268435456, 29'd65536, 29'd65536);
    run_batch(3, 4);
    set_regs(odu_pkg::VOL_RESET, odu_pkg::CFG_W'(odu_pkg::MOVE_RESET),
             odu_pkg::CFG_W'(odu_pkg::MIN_RESET));

    // store full: extra load dropped, its last flag still starts the update
    for (int k = 0; k <= odu_pkg::MAX_ELEMENTS; k++)
      send(load_item(odu_pkg::DENS_W'($urandom_range(0, 65536)), $urandom, 1'b1,
                     k == odu_pkg::MAX_ELEMENTS), 0);
    send(read_item(12'd0), 0);
    send(read_item(12'hFFF), 0);
    send(read_item(12'd2048), 0);

    // random batches, registers changed every few batches
    n_items = 0;
    while (n_items < 550) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0: set_regs(odu_pkg::CFG_W'($urandom_range(0, 268435456)),
                      odu_pkg::CFG_W'($urandom_range(0, 65536)),
                      odu_pkg::CFG_W'($urandom_range(0, 65536)));
          1: set_regs(odu_pkg::CFG_W'($urandom_range(0, 600000)),
                      odu_pkg::CFG_W'($urandom_range(0, 20000)),
                      odu_pkg::CFG_W'($urandom_range(0, 3000)));
          default: set_regs(odu_pkg::VOL_RESET, odu_pkg::CFG_W'(odu_pkg::MOVE_RESET),
                            odu_pkg::CFG_W'(odu_pkg::MIN_RESET));
        endcase
      end
      if ($urandom_range(0, 11) == 0) begin
        // unterminated loads: they join the next batch
        send(rand_load(1'b0), pick_gap());
      end
      run_batch(($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6),
                $urandom_range(3, 12));
    end

    drain();
    if (sb.n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
